@@ hdl/rtpnfa_pkg.sv @@
// Package for the H.264 RTP NAL frame assembler: field widths, NAL type codes,
// strip codes and the transaction types shared by the front, queue and back stages.
// No dependencies.
package rtpnfa_pkg;

    // Field widths
    localparam int SEQ_W   = 16;
    localparam int BYTE_W  = 8;
    localparam int PLEN_W  = 16;
    localparam int FRAME_W = 21;
    localparam int TYPE_W  = 5;
    localparam int STRIP_W = 2;

    // Slice header window; second_byte fills its top byte (8 to 32 bits)
    localparam int SLICE_WINDOW_BITS = 8;

    // Configuration and queue defaults
    localparam logic [FRAME_W-1:0] FRAME_CAPACITY_RESET = 21'd153600;
    localparam int                 QUEUE_DEPTH          = 2;
    localparam logic [FRAME_W-1:0] START_CODE_BYTES     = 21'd4;

    // NAL unit type codes
    localparam logic [TYPE_W-1:0] UNIT_SLICE = 5'd1;
    localparam logic [TYPE_W-1:0] UNIT_IDR   = 5'd5;
    localparam logic [TYPE_W-1:0] UNIT_SPS   = 5'd7;
    localparam logic [TYPE_W-1:0] UNIT_LAST  = 5'd10;
    localparam logic [TYPE_W-1:0] UNIT_FU_A  = 5'h1C;

    // FU header start bit position
    localparam int FU_START_BIT = 7;

    // Leading bytes dropped from the payload
    localparam logic [STRIP_W-1:0] STRIP_NONE     = 2'd0;
    localparam logic [STRIP_W-1:0] STRIP_FU_START = 2'd1;
    localparam logic [STRIP_W-1:0] STRIP_FU_OTHER = 2'd2;

    // Slice_type codes that mark an I slice after first_mb_in_slice == 0
    localparam logic [2:0] UE_CODE_TWO   = 3'b011;
    localparam logic [6:0] UE_CODE_SEVEN = 7'b0001000;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq_number;
        logic [BYTE_W-1:0] nal_head;
        logic [BYTE_W-1:0] second_byte;
        logic [PLEN_W-1:0] payload_length;
    } t_in_item;

    typedef struct packed {
        logic               accepted;
        logic               frame_done;
        logic [FRAME_W-1:0] done_length;
        logic [TYPE_W-1:0]  done_nal_type;
        logic               done_keyframe;
        logic [TYPE_W-1:0]  unit_type;
        logic               insert_start_code;
        logic [STRIP_W-1:0] strip_count;
        logic [BYTE_W-1:0]  rebuilt_header;
        logic [SEQ_W-1:0]   lost_packets;
        logic               first_i_slice;
    } t_out_item;

    // Classified packet handed from front to back
    typedef struct packed {
        logic [SEQ_W-1:0]   seq_number;
        logic [TYPE_W-1:0]  unit_type;
        logic               rejected;
        logic               fu;
        logic               fu_start;
        logic               first_mb;
        logic               first_i;
        logic [STRIP_W-1:0] strip_count;
        logic [BYTE_W-1:0]  rebuilt_header;
        logic [PLEN_W-1:0]  data_len;
    } t_cls;

endpackage

@@ hdl/rtpnfa_if.sv @@
// Valid/ready channel interfaces for packet descriptors in and results out.
// Depends on rtpnfa_pkg for the payload types.
interface rtpnfa_in_if;
    logic                  valid;
    logic                  ready;
    rtpnfa_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rtpnfa_out_if;
    logic                  valid;
    logic                  ready;
    rtpnfa_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/rtpnfa_front.sv @@
// Front stage: accepts packet descriptors, classifies NAL/FU-A, decodes the
// slice-header Exp-Golomb codes and registers the result. Depends on rtpnfa_pkg.
module rtpnfa_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rtpnfa_in_if.sink         i_in,
    output logic              o_push_valid,
    output rtpnfa_pkg::t_cls  o_push_item,
    input  logic              i_push_ready
);

    localparam int WIN_W = rtpnfa_pkg::SLICE_WINDOW_BITS;

    logic                                  r_valid;
    rtpnfa_pkg::t_cls                      r_cls;
    rtpnfa_pkg::t_cls                      n_cls;

    logic [rtpnfa_pkg::TYPE_W-1:0]         head_type;
    logic [rtpnfa_pkg::TYPE_W-1:0]         eff_type;
    logic                                  fu;
    logic                                  fu_start;
    logic                                  single_ok;
    logic                                  is_slice;
    logic [WIN_W-1:0]                      win;
    logic                                  ue_first_zero;
    logic                                  ue_i_slice;
    logic [rtpnfa_pkg::STRIP_W-1:0]        strip;
    logic                                  accept;

    assign accept     = i_in.valid && i_in.ready;
    assign i_in.ready = !r_valid || i_push_ready;

    // Classify the packet
    always_comb begin
        head_type = i_in.data.nal_head[rtpnfa_pkg::TYPE_W-1:0];
        fu        = (head_type == rtpnfa_pkg::UNIT_FU_A);
        eff_type  = fu ? i_in.data.second_byte[rtpnfa_pkg::TYPE_W-1:0] : head_type;
        fu_start  = fu && i_in.data.second_byte[rtpnfa_pkg::FU_START_BIT];
        single_ok = !fu && ((head_type == rtpnfa_pkg::UNIT_SLICE) ||
                    (head_type inside {[rtpnfa_pkg::UNIT_IDR:rtpnfa_pkg::UNIT_LAST]}));
        is_slice  = (eff_type == rtpnfa_pkg::UNIT_SLICE) ||
                    (eff_type == rtpnfa_pkg::UNIT_IDR);
    end

    // Decode first_mb_in_slice == 0 and slice_type 2 or 7 from the window
    always_comb begin
        win           = WIN_W'(i_in.data.second_byte) << (WIN_W - rtpnfa_pkg::BYTE_W);
        ue_first_zero = win[WIN_W-1];
        ue_i_slice    = (win[WIN_W-2 -: 3] == rtpnfa_pkg::UE_CODE_TWO) ||
                        (win[WIN_W-2 -: 7] == rtpnfa_pkg::UE_CODE_SEVEN);
    end

    // Build the classified transaction
    always_comb begin
        if (fu) begin
            strip = fu_start ? rtpnfa_pkg::STRIP_FU_START : rtpnfa_pkg::STRIP_FU_OTHER;
        end else begin
            strip = rtpnfa_pkg::STRIP_NONE;
        end
        n_cls.seq_number  = i_in.data.seq_number;
        n_cls.unit_type   = eff_type;
        n_cls.rejected    = !fu && !single_ok;
        n_cls.fu          = fu;
        n_cls.fu_start    = fu_start;
        n_cls.strip_count = strip;
        n_cls.rebuilt_header = fu_start ?
            {i_in.data.nal_head[rtpnfa_pkg::BYTE_W-1:rtpnfa_pkg::TYPE_W], eff_type} :
            '0;
        if (fu) begin
            n_cls.first_mb = fu_start && is_slice;
            n_cls.first_i  = fu_start && (eff_type == rtpnfa_pkg::UNIT_IDR);
        end else begin
            n_cls.first_mb = single_ok && is_slice && ue_first_zero;
            n_cls.first_i  = single_ok && is_slice && ue_first_zero && ue_i_slice;
        end
        if (i_in.data.payload_length > rtpnfa_pkg::PLEN_W'(strip)) begin
            n_cls.data_len = i_in.data.payload_length - rtpnfa_pkg::PLEN_W'(strip);
        end else begin
            n_cls.data_len = '0;
        end
    end

    // Hold the classified transaction until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cls <= n_cls;
        end
    end

    assign o_push_valid = r_valid;
    assign o_push_item  = r_cls;

endmodule

@@ hdl/rtpnfa_queue.sv @@
// Short FIFO of classified packets between the front and back stages.
// Depends on rtpnfa_pkg for the entry type.
module rtpnfa_queue #(
    parameter int DEPTH = rtpnfa_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  rtpnfa_pkg::t_cls  i_push_item,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output rtpnfa_pkg::t_cls  o_pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rtpnfa_pkg::t_cls  r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_item   = r_mem[r_rd_ptr];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store the entry
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

@@ hdl/rtpnfa_back.sv @@
// Back stage: applies the sequence, SPS-wait and frame-length state to each
// classified packet and registers the result. Depends on rtpnfa_pkg.
module rtpnfa_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [rtpnfa_pkg::FRAME_W-1:0]     i_frame_capacity,
    input  logic                               i_pop_valid,
    output logic                               o_pop_ready,
    input  rtpnfa_pkg::t_cls                   i_item,
    rtpnfa_out_if.source                       o_out
);

    localparam int SUM_W = rtpnfa_pkg::FRAME_W + 1;

    logic [rtpnfa_pkg::SEQ_W-1:0]    r_last_seq;
    logic [rtpnfa_pkg::SEQ_W-1:0]    n_last_seq;
    logic                            r_waiting;
    logic                            n_waiting;
    logic [rtpnfa_pkg::FRAME_W-1:0]  r_frame_len;
    logic [rtpnfa_pkg::FRAME_W-1:0]  n_frame_len;
    logic [rtpnfa_pkg::TYPE_W-1:0]   r_frame_type;
    logic [rtpnfa_pkg::TYPE_W-1:0]   n_frame_type;
    logic                            r_out_valid;
    rtpnfa_pkg::t_out_item           r_out;
    rtpnfa_pkg::t_out_item           n_out;

    logic                            pop;
    logic                            gap;
    logic                            wait0;
    logic [rtpnfa_pkg::FRAME_W-1:0]  len0;
    logic                            done;
    logic [rtpnfa_pkg::FRAME_W-1:0]  len1;
    logic [SUM_W-1:0]                sum_data;
    logic [SUM_W-1:0]                need;
    logic                            start_code;

    assign o_pop_ready = !r_out_valid || o_out.ready;
    assign pop         = i_pop_valid && o_pop_ready;

    // Sequence gap, frame boundary and capacity check
    always_comb begin
        gap   = (r_last_seq + 1'b1 != i_item.seq_number) && (r_last_seq != '0) &&
                (i_item.seq_number != '0);
        wait0 = gap || r_waiting;
        len0  = gap ? '0 : r_frame_len;
        done  = (len0 != '0) && ((r_frame_type != i_item.unit_type) || i_item.first_mb);
        len1  = done ? '0 : len0;
        sum_data   = SUM_W'(len1) + SUM_W'(i_item.data_len);
        need       = sum_data + SUM_W'(rtpnfa_pkg::START_CODE_BYTES);
        start_code = !i_item.fu || i_item.fu_start;

        n_last_seq   = i_item.seq_number;
        n_waiting    = wait0;
        n_frame_len  = len0;
        n_frame_type = r_frame_type;

        n_out = '0;
        n_out.unit_type    = i_item.unit_type;
        n_out.lost_packets = gap ? i_item.seq_number - r_last_seq : '0;

        if (!i_item.rejected) begin
            n_out.strip_count    = i_item.strip_count;
            n_out.rebuilt_header = i_item.rebuilt_header;
            n_out.first_i_slice  = i_item.first_i;
            if (i_item.unit_type == rtpnfa_pkg::UNIT_SPS) begin
                n_waiting = 1'b0;
            end
            if (n_waiting) begin
                // drop while waiting for SPS
                n_frame_len = len0;
            end else begin
                n_out.frame_done = done;
                if (done) begin
                    n_out.done_length   = len0;
                    n_out.done_nal_type = r_frame_type;
                    n_out.done_keyframe = (r_frame_type == rtpnfa_pkg::UNIT_SPS);
                end
                if (need > SUM_W'(i_frame_capacity)) begin
                    // capacity exceeded: drop frame and wait
                    n_waiting   = 1'b1;
                    n_frame_len = '0;
                end else begin
                    n_out.accepted          = 1'b1;
                    n_out.insert_start_code = start_code;
                    if (len1 == '0) begin
                        n_frame_type = i_item.unit_type;
                    end
                    n_frame_len = start_code ? need[rtpnfa_pkg::FRAME_W-1:0] :
                                               sum_data[rtpnfa_pkg::FRAME_W-1:0];
                end
            end
        end
    end

    // Advance state on each popped transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_seq   <= '0;
            r_waiting    <= 1'b0;
            r_frame_len  <= '0;
            r_frame_type <= '0;
        end else if (pop) begin
            r_last_seq   <= n_last_seq;
            r_waiting    <= n_waiting;
            r_frame_len  <= n_frame_len;
            r_frame_type <= n_frame_type;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pop) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

@@ hdl/h264_rtp_nal_frame_assembler_core.sv @@
// Top level of the H.264 RTP NAL frame assembler (FU-A depacketizer).
// Depends on rtpnfa_pkg, rtpnfa_if, rtpnfa_front, rtpnfa_queue and rtpnfa_back.
//
// Usage:
//   i_in carries one packet descriptor per transaction (sequence number, first
//   two payload bytes, payload length); o_out returns exactly one result per
//   packet, in order. Both use valid/ready; a transaction moves when both are high.
//   i_cfg_wr_en/i_cfg_wr_data write frame_capacity; write only while idle.
//   Throughput: one packet per cycle while o_out.ready stays high. The back stage
//   updates the sequence and frame-length state and does the 22-bit capacity
//   add/compare combinationally. Path: an input transaction passes the front
//   register, the queue entry and the output register in turn; o_out.valid
//   rises when the output register loads.
//   Reset (synchronous, active low) clears the sequence, SPS-wait and frame
//   state, empties the queue and sets frame_capacity to 153600.
//   When the receiver stalls, the output register holds its result, the queue
//   absorbs up to QUEUE_DEPTH more packets plus one in the front register,
//   and then i_in.ready drops.
module h264_rtp_nal_frame_assembler_core #(
    parameter int QUEUE_DEPTH = rtpnfa_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [rtpnfa_pkg::FRAME_W-1:0]  i_cfg_wr_data,
    rtpnfa_in_if.sink                       i_in,
    rtpnfa_out_if.source                    o_out
);

    logic [rtpnfa_pkg::FRAME_W-1:0]  r_frame_capacity;
    logic                            push_valid;
    logic                            push_ready;
    rtpnfa_pkg::t_cls                push_item;
    logic                            pop_valid;
    logic                            pop_ready;
    rtpnfa_pkg::t_cls                pop_item;

    // Capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_capacity <= rtpnfa_pkg::FRAME_CAPACITY_RESET;
        end else if (i_cfg_wr_en) begin
            r_frame_capacity <= i_cfg_wr_data;
        end
    end

    rtpnfa_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .o_push_item  (push_item),
        .i_push_ready (push_ready)
    );

    rtpnfa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_item   (pop_item)
    );

    rtpnfa_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_frame_capacity (r_frame_capacity),
        .i_pop_valid      (pop_valid),
        .o_pop_ready      (pop_ready),
        .i_item           (pop_item),
        .o_out            (o_out)
    );

endmodule

@@ bench/rtpnfa_assembly_check.sv @@
// Result checker for the H.264 RTP NAL frame assembler: predicts one result per
// accepted packet descriptor and compares it with the block's output channel.
// Depends on rtpnfa_pkg and rtpnfa_if.
module rtpnfa_assembly_check (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [rtpnfa_pkg::FRAME_W-1:0] i_cfg_wr_data,
    rtpnfa_in_if                           i_pkt,
    rtpnfa_out_if                          i_res,
    output int                             o_mismatches,
    output int                             o_outstanding
);

    // Keep the log readable when a bug hits every transaction
    localparam int REPORT_LIMIT = 200;
    localparam int WIN_BITS     = rtpnfa_pkg::SLICE_WINDOW_BITS;

    // Predicted assembler state and the frame capacity register
    logic [rtpnfa_pkg::SEQ_W-1:0]   seq_prev;
    logic                           sps_wait;
    logic [rtpnfa_pkg::FRAME_W-1:0] frame_bytes;
    logic [rtpnfa_pkg::TYPE_W-1:0]  frame_type;
    logic [rtpnfa_pkg::FRAME_W-1:0] capacity;

    rtpnfa_pkg::t_out_item          pending_results[$];
    rtpnfa_pkg::t_out_item          want;
    int                             mismatches = 0;

    function automatic logic slice_bit(input logic [31:0] win, input int pos);
        if (pos >= WIN_BITS) begin
            return 1'b0;
        end
        return win[WIN_BITS-1-pos];
    endfunction

    // Unsigned Exp-Golomb code from the slice header window; 0 when no leading one
    function automatic logic read_golomb(input logic [31:0] win, inout int pos,
                                         output longint unsigned code);
        int zeros;
        int p;
        zeros = 0;
        p     = pos;
        code  = 0;
        while (p < WIN_BITS && !slice_bit(win, p)) begin
            zeros++;
            p++;
        end
        if (p >= WIN_BITS) begin
            return 1'b0;
        end
        p++;
        for (int i = 0; i < zeros; i++) begin
            code = (code << 1) | slice_bit(win, p);
            p++;
        end
        code = code + (64'd1 << zeros) - 1;
        pos  = p;
        return 1'b1;
    endfunction

    // Classify one packet, advance the frame state and build its result
    function automatic rtpnfa_pkg::t_out_item assemble_packet(
            input rtpnfa_pkg::t_in_item pkt);
        rtpnfa_pkg::t_out_item          r;
        logic [rtpnfa_pkg::TYPE_W-1:0]  ut;
        logic [rtpnfa_pkg::STRIP_W-1:0] strip;
        logic                           fu;
        logic                           fu_start;
        logic                           first_mb;
        logic                           first_i;
        logic                           start_code;
        logic [31:0]                    win;
        int                             pos;
        longint unsigned                code;
        int unsigned                    data_len;
        int unsigned                    need;

        r        = '0;
        strip    = rtpnfa_pkg::STRIP_NONE;
        fu       = 1'b0;
        fu_start = 1'b0;
        first_mb = 1'b0;
        first_i  = 1'b0;

        // Sequence break: drop the partial frame and wait for SPS
        if (pkt.seq_number != rtpnfa_pkg::SEQ_W'(seq_prev + 16'd1) && seq_prev != '0
                && pkt.seq_number != '0) begin
            r.lost_packets = pkt.seq_number - seq_prev;
            sps_wait       = 1'b1;
            frame_bytes    = '0;
        end
        seq_prev = pkt.seq_number;

        ut = pkt.nal_head[rtpnfa_pkg::TYPE_W-1:0];
        if (ut == rtpnfa_pkg::UNIT_FU_A) begin
            fu = 1'b1;
            ut = pkt.second_byte[rtpnfa_pkg::TYPE_W-1:0];
            if (pkt.second_byte[rtpnfa_pkg::FU_START_BIT]) begin
                fu_start = 1'b1;
                if (ut == rtpnfa_pkg::UNIT_SLICE || ut == rtpnfa_pkg::UNIT_IDR) begin
                    first_mb = 1'b1;
                    first_i  = (ut == rtpnfa_pkg::UNIT_IDR);
                end
                r.rebuilt_header = {pkt.nal_head[7:5], ut};
                strip = rtpnfa_pkg::STRIP_FU_START;
            end else begin
                strip = rtpnfa_pkg::STRIP_FU_OTHER;
            end
        end else if (ut == rtpnfa_pkg::UNIT_SLICE ||
                     (ut >= rtpnfa_pkg::UNIT_IDR && ut <= rtpnfa_pkg::UNIT_LAST)) begin
            if (ut == rtpnfa_pkg::UNIT_SLICE || ut == rtpnfa_pkg::UNIT_IDR) begin
                win = 32'(pkt.second_byte) << (WIN_BITS - 8);
                pos = 0;
                if (read_golomb(win, pos, code) && code == 0) begin
                    first_mb = 1'b1;
                    if (read_golomb(win, pos, code) && (code == 2 || code == 7)) begin
                        first_i = 1'b1;
                    end
                end
            end
        end else begin
            // Unsupported type: only the type and the gap are reported
            r.unit_type = ut;
            return r;
        end

        r.unit_type     = ut;
        r.strip_count   = strip;
        r.first_i_slice = first_i;

        if (ut == rtpnfa_pkg::UNIT_SPS) begin
            sps_wait = 1'b0;
        end
        if (sps_wait) begin
            return r;
        end

        // Close the current frame on a type change or a new first macroblock
        if (frame_bytes != '0 && (frame_type != ut || first_mb)) begin
            r.frame_done    = 1'b1;
            r.done_length   = frame_bytes;
            r.done_nal_type = frame_type;
            r.done_keyframe = (frame_type == rtpnfa_pkg::UNIT_SPS);
            frame_bytes     = '0;
        end

        data_len = (pkt.payload_length > strip) ? pkt.payload_length - strip : 0;
        need     = frame_bytes + data_len + rtpnfa_pkg::START_CODE_BYTES;
        if (need > capacity) begin
            sps_wait    = 1'b1;
            frame_bytes = '0;
        end else begin
            r.accepted = 1'b1;
            if (frame_bytes == '0) begin
                frame_type = ut;
            end
            start_code          = !fu || fu_start;
            r.insert_start_code = start_code;
            frame_bytes = frame_bytes + (start_code ? rtpnfa_pkg::START_CODE_BYTES : '0)
                        + rtpnfa_pkg::FRAME_W'(data_len);
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("%0t  %s: expected %0h, got %0h", $time, name, want_v, got_v);
            end
        end
    endtask

    // Compare results first, then queue the prediction for a new packet
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seq_prev    = '0;
            sps_wait    = 1'b0;
            frame_bytes = '0;
            frame_type  = '0;
            capacity    = rtpnfa_pkg::FRAME_CAPACITY_RESET;
            pending_results.delete();
        end else begin
            if (i_cfg_wr_en) begin
                capacity = i_cfg_wr_data;
            end
            if (i_res.valid && i_res.ready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%0t  result with no packet outstanding: expected none, got %h",
                                 $time, i_res.data);
                    end
                end else begin
                    want = pending_results.pop_front();
                    check_field("accepted", want.accepted, i_res.data.accepted);
                    check_field("frame_done", want.frame_done, i_res.data.frame_done);
                    check_field("done_length", want.done_length, i_res.data.done_length);
                    check_field("done_nal_type", want.done_nal_type,
                                i_res.data.done_nal_type);
                    check_field("done_keyframe", want.done_keyframe,
                                i_res.data.done_keyframe);
                    check_field("unit_type", want.unit_type, i_res.data.unit_type);
                    check_field("insert_start_code", want.insert_start_code,
                                i_res.data.insert_start_code);
                    check_field("strip_count", want.strip_count, i_res.data.strip_count);
                    check_field("rebuilt_header", want.rebuilt_header,
                                i_res.data.rebuilt_header);
                    check_field("lost_packets", want.lost_packets, i_res.data.lost_packets);
                    check_field("first_i_slice", want.first_i_slice,
                                i_res.data.first_i_slice);
                end
            end
            if (i_pkt.valid && i_pkt.ready) begin
                pending_results.push_back(assemble_packet(i_pkt.data));
            end
        end
        o_outstanding <= pending_results.size();
        o_mismatches  <= mismatches;
    end

endmodule

@@ bench/tb_h264_rtp_nal_frame_assembler_core.sv @@
// Testbench top for h264_rtp_nal_frame_assembler_core: drives packet descriptors
// and capacity settings with random idling on both channels and gives the verdict.
// Depends on rtpnfa_pkg, rtpnfa_if, the block itself and rtpnfa_assembly_check.
module tb_h264_rtp_nal_frame_assembler_core;

    // NAL types that only this bench sends by name
    localparam logic [rtpnfa_pkg::TYPE_W-1:0] UNIT_SEI = 5'd6;
    localparam logic [rtpnfa_pkg::TYPE_W-1:0] UNIT_PPS = 5'd8;
    localparam logic [rtpnfa_pkg::TYPE_W-1:0] UNIT_AUD = 5'd9;

    localparam int MAX_WAIT       = 17;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 3000;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_wr_en;
    logic [rtpnfa_pkg::FRAME_W-1:0] cfg_wr_data;
    int                             fail_count;
    int                             outstanding;

    rtpnfa_in_if  pkt_ch ();
    rtpnfa_out_if res_ch ();

    logic [rtpnfa_pkg::SEQ_W-1:0] seq_next;
    int                           sent_items;
    int                           send_quiet;
    int                           recv_quiet;
    int                           idle_cycles;

    h264_rtp_nal_frame_assembler_core dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_in         (pkt_ch),
        .o_out        (res_ch)
    );

    rtpnfa_assembly_check u_assembly_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_pkt        (pkt_ch),
        .i_res        (res_ch),
        .o_mismatches (fail_count),
        .o_outstanding(outstanding)
    );

    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Idle cycles before a transaction; now and then a run of back-to-back ones
    function automatic int draw_wait(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            quiet_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic logic [rtpnfa_pkg::BYTE_W-1:0] nal_byte(
            input logic [rtpnfa_pkg::TYPE_W-1:0] t);
        return {3'($urandom), t};
    endfunction

    // Mostly typical packet sizes, some tiny, some up to the field maximum
    function automatic logic [rtpnfa_pkg::PLEN_W-1:0] draw_length();
        case ($urandom_range(0, 15))
            0: return rtpnfa_pkg::PLEN_W'($urandom_range(0, 3));
            1: return rtpnfa_pkg::PLEN_W'($urandom);
            default: return rtpnfa_pkg::PLEN_W'($urandom_range(4, 1400));
        endcase
    endfunction

    // First slice-header byte: first macroblock with I types, or anything else
    function automatic logic [rtpnfa_pkg::BYTE_W-1:0] slice_header_byte();
        case ($urandom_range(0, 5))
            0: return {1'b1, rtpnfa_pkg::UE_CODE_TWO, 4'($urandom)};
            1: return {1'b1, rtpnfa_pkg::UE_CODE_SEVEN};
            2, 3: return {1'b1, 7'($urandom)};
            default: return {1'b0, 7'($urandom)};
        endcase
    endfunction

    // Offer one descriptor with the next sequence number and hold it until taken
    task automatic send_packet(input logic [rtpnfa_pkg::BYTE_W-1:0] head,
                               input logic [rtpnfa_pkg::BYTE_W-1:0] second,
                               input logic [rtpnfa_pkg::PLEN_W-1:0] plen);
        int                   gap;
        rtpnfa_pkg::t_in_item pkt;
        gap = draw_wait(send_quiet);
        pkt = '{seq_number: seq_next, nal_head: head, second_byte: second,
                payload_length: plen};
        seq_next = seq_next + 1'b1;
        sent_items++;
        if (gap > 0) begin
            pkt_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pkt_ch.data  <= pkt;
        pkt_ch.valid <= 1'b1;
        do @(posedge clk); while (!pkt_ch.ready);
    endtask

    // One fragmented unit: start, a few middles, end
    task automatic send_fu_unit(input logic [rtpnfa_pkg::TYPE_W-1:0] t);
        logic [rtpnfa_pkg::BYTE_W-1:0] indicator;
        int                            middle;
        indicator = {3'($urandom), rtpnfa_pkg::UNIT_FU_A};
        middle    = $urandom_range(0, 4);
        send_packet(indicator, {2'b10, 1'($urandom), t}, draw_length());
        repeat (middle) send_packet(indicator, {2'b00, 1'($urandom), t}, draw_length());
        send_packet(indicator, {2'b01, 1'($urandom), t}, draw_length());
    endtask

    // Mostly well-formed stream content, plus noise and sequence breaks
    task automatic send_random_unit();
        int                            pick;
        logic [rtpnfa_pkg::TYPE_W-1:0] t;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            send_packet(nal_byte(rtpnfa_pkg::UNIT_SPS), 8'($urandom), draw_length());
        end else if (pick < 14) begin
            case ($urandom_range(0, 3))
                0: t = UNIT_SEI;
                1: t = UNIT_PPS;
                2: t = UNIT_AUD;
                default: t = rtpnfa_pkg::UNIT_LAST;
            endcase
            send_packet(nal_byte(t), 8'($urandom), draw_length());
        end else if (pick < 44) begin
            t = $urandom_range(0, 1) ? rtpnfa_pkg::UNIT_SLICE : rtpnfa_pkg::UNIT_IDR;
            send_packet(nal_byte(t), slice_header_byte(), draw_length());
        end else if (pick < 80) begin
            case ($urandom_range(0, 7))
                0: t = rtpnfa_pkg::UNIT_SPS;
                1: t = rtpnfa_pkg::TYPE_W'($urandom);
                2, 3: t = rtpnfa_pkg::UNIT_IDR;
                default: t = rtpnfa_pkg::UNIT_SLICE;
            endcase
            send_fu_unit(t);
        end else if (pick < 92) begin
            send_packet(8'($urandom), 8'($urandom), rtpnfa_pkg::PLEN_W'($urandom));
        end else begin
            // Break the sequence: zero, wrap point, repeat or a random jump
            case ($urandom_range(0, 3))
                0: seq_next = '0;
                1: seq_next = '1;
                2: seq_next = seq_next - 1'b1;
                default: seq_next = rtpnfa_pkg::SEQ_W'($urandom);
            endcase
            send_packet(nal_byte(rtpnfa_pkg::UNIT_SLICE), slice_header_byte(),
                        draw_length());
        end
    endtask

    task automatic write_capacity(input logic [rtpnfa_pkg::FRAME_W-1:0] cap);
        cfg_wr_data <= cap;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Stop offering and wait until every predicted result has come back
    task automatic drain();
        pkt_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(input logic [rtpnfa_pkg::FRAME_W-1:0] cap, input int items);
        int stop_at;
        drain();
        write_capacity(cap);
        stop_at = sent_items + items;
        while (sent_items < stop_at) send_random_unit();
    endtask

    // Sender: reset, directed stream, then random phases at several capacities
    initial begin
        pkt_ch.valid <= 1'b0;
        pkt_ch.data  <= '0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_data  <= '0;
        rst_n        <= 1'b0;
        seq_next   = 16'd1;
        sent_items = 0;
        send_quiet = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        write_capacity(rtpnfa_pkg::FRAME_CAPACITY_RESET);

        // SPS, PPS, then an IDR picture with an empty and a maximal payload
        send_packet({3'b011, rtpnfa_pkg::UNIT_SPS}, 8'h42, 16'd12);
        send_packet({3'b011, UNIT_PPS}, 8'hCE, 16'd4);
        send_packet({3'b011, rtpnfa_pkg::UNIT_IDR}, {1'b1, rtpnfa_pkg::UE_CODE_SEVEN}, 16'd0);
        send_packet({3'b011, rtpnfa_pkg::UNIT_IDR}, 8'h40, 16'hFFFF);
        // Non-IDR I slice, then a header with no leading one in the window
        send_packet({3'b010, rtpnfa_pkg::UNIT_SLICE},
                    {1'b1, rtpnfa_pkg::UE_CODE_TWO, 4'hF}, 16'd900);
        send_packet({3'b010, rtpnfa_pkg::UNIT_SLICE}, 8'h00, 16'd800);
        // Fragmented IDR with payloads no longer than the stripped bytes, then a fragmented slice
        send_packet({3'b011, rtpnfa_pkg::UNIT_FU_A}, {3'b100, rtpnfa_pkg::UNIT_IDR}, 16'd1);
        send_packet({3'b011, rtpnfa_pkg::UNIT_FU_A}, {3'b000, rtpnfa_pkg::UNIT_IDR}, 16'd1);
        send_packet({3'b011, rtpnfa_pkg::UNIT_FU_A}, {3'b010, rtpnfa_pkg::UNIT_IDR}, 16'd2);
        send_packet({3'b010, rtpnfa_pkg::UNIT_FU_A}, {3'b100, rtpnfa_pkg::UNIT_SLICE},
                    16'd1400);
        send_packet({3'b010, rtpnfa_pkg::UNIT_FU_A}, {3'b010, rtpnfa_pkg::UNIT_SLICE},
                    16'd1400);
        // Unsupported types at both ends of the byte range, then SEI, AUD and type 10
        send_packet(8'h00, 8'h00, 16'd0);
        send_packet(8'hFF, 8'hFF, 16'hFFFF);
        send_packet({3'b000, UNIT_SEI}, 8'h05, 16'd20);
        send_packet({3'b000, UNIT_AUD}, 8'h10, 16'd2);
        send_packet({3'b000, rtpnfa_pkg::UNIT_LAST}, 8'h00, 16'd1);
        // Lost packets: wait for SPS, recovered by a fragmented SPS
        seq_next = seq_next + 16'd5;
        send_packet({3'b010, rtpnfa_pkg::UNIT_SLICE}, 8'h80, 16'd100);
        send_packet({3'b011, rtpnfa_pkg::UNIT_FU_A}, {3'b100, rtpnfa_pkg::UNIT_SPS}, 16'd30);
        // Grow one frame past the capacity, then a slice while waiting
        repeat (3) send_packet({3'b011, rtpnfa_pkg::UNIT_SPS}, 8'h00, 16'hFFFF);
        send_packet({3'b010, rtpnfa_pkg::UNIT_SLICE}, 8'hFF, 16'd50);
        // Sequence wrap through zero
        seq_next = '1;
        send_packet({3'b011, rtpnfa_pkg::UNIT_SPS}, 8'h01, 16'd8);
        send_packet({3'b010, rtpnfa_pkg::UNIT_SLICE}, 8'hB4, 16'd64);
        send_packet({3'b010, rtpnfa_pkg::UNIT_SLICE}, 8'h7F, 16'd64);

        run_phase(21'd4, 150);
        run_phase(21'd1048576, 300);
        run_phase(rtpnfa_pkg::FRAME_W'($urandom_range(64, 4096)), 300);
        run_phase(rtpnfa_pkg::FRAME_CAPACITY_RESET, 250);
        run_phase(rtpnfa_pkg::FRAME_W'($urandom_range(4, 1048576)), 250);
        drain();

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Receiver: random stalls, with two long holds to back the block up
    initial begin
        int stall;
        int taken;
        res_ch.ready <= 1'b0;
        taken      = 0;
        recv_quiet = 0;
        @(posedge clk);
        forever begin
            stall = draw_wait(recv_quiet);
            if (taken == 300 || taken == 900) begin
                stall = HOLD_CYCLES;
            end
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
            taken++;
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((pkt_ch.valid && pkt_ch.ready) || (res_ch.valid && res_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Regression FAIL");
        $finish;
    end

endmodule

@@ files.f @@
hdl/rtpnfa_pkg.sv
hdl/rtpnfa_if.sv
hdl/rtpnfa_front.sv
hdl/rtpnfa_queue.sv
hdl/rtpnfa_back.sv
hdl/h264_rtp_nal_frame_assembler_core.sv
bench/rtpnfa_assembly_check.sv
bench/tb_h264_rtp_nal_frame_assembler_core.sv
